>>> src/led_pattern_sequencer_top_assert.svh
// ----------------------------------------------------------------------------
// LED pattern sequencer assertion macros
// Shared concurrent assertion forms used by the sequencer modules.
// ----------------------------------------------------------------------------
`ifndef LED_PATTERN_SEQUENCER_TOP_ASSERT_SVH
`define LED_PATTERN_SEQUENCER_TOP_ASSERT_SVH

// The condition must hold at every clock edge out of reset.
`define LPS_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("led_pattern_sequencer: invariant violated");

// The consequent must hold in the same cycle as the antecedent.
`define LPS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("led_pattern_sequencer: implication violated");

// The consequent must hold in the cycle after the antecedent.
`define LPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("led_pattern_sequencer: next-cycle check violated");

`endif

>>> src/lps_pkg.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer package
// Sizes, item and status types, and the fixed (level, duration) pattern ROM.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int CHANNELS    = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    localparam int OP_W     = 2;
    localparam int EFFECT_W = 3;
    localparam int LEVEL_W  = 2;
    localparam int HOLD_W   = 8;
    localparam int ARG_W    = 3;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    localparam logic [HOLD_W-1:0] HOLD_SHORT = 8'd10;
    localparam logic [HOLD_W-1:0] HOLD_LONG  = 8'd50;
    localparam logic [HOLD_W-1:0] HOLD_PAUSE = 8'd210;

    localparam int ROM_PAIRS     = 22;
    localparam int PI_W          = $clog2(ROM_PAIRS);
    localparam int KNOWN_EFFECTS = 6;

    typedef enum logic [OP_W-1:0] {
        OP_POST = 2'd0,
        OP_LOAD = 2'd1,
        OP_TICK = 2'd2
    } op_t;

    typedef enum logic [EFFECT_W-1:0] {
        EFF_DARK   = 3'd0,
        EFF_LIGHT  = 3'd1,
        EFF_BLINK1 = 3'd2,
        EFF_BLINK2 = 3'd3,
        EFF_BLINK3 = 3'd4,
        EFF_BLINK4 = 3'd5
    } effect_t;

    typedef enum logic [1:0] {
        KIND_PAIR  = 2'd0,
        KIND_END   = 2'd1,
        KIND_AGAIN = 2'd2
    } kind_t;

    // For a repeat marker, arg is the jump distance; otherwise it is the level.
    typedef struct packed {
        kind_t              kind;
        logic [ARG_W-1:0]   arg;
        logic [HOLD_W-1:0]  hold;
    } rom_pair_t;

    typedef struct packed {
        op_t                  op;
        logic                 channel;
        logic [EFFECT_W-1:0]  effect;
        logic                 clear_first;
    } item_t;

    typedef struct packed {
        logic                 fire;
        op_t                  op;
        logic                 post_hit;
        logic                 clear_first;
        logic [EFFECT_W-1:0]  effect;
    } chan_ctrl_t;

    typedef struct packed {
        logic level;
        logic busy;
        logic dropped;
    } chan_stat_t;

    localparam rom_pair_t END_PAIR = '{KIND_END, 3'd0, 8'd0};

    localparam rom_pair_t PAT_ROM [ROM_PAIRS] = '{
        // dark
        '{KIND_PAIR, 3'd0, HOLD_SHORT}, '{KIND_END, 3'd0, 8'd0},
        // light
        '{KIND_PAIR, 3'd1, HOLD_SHORT}, '{KIND_END, 3'd0, 8'd0},
        // blink1
        '{KIND_PAIR, 3'd1, HOLD_LONG}, '{KIND_PAIR, 3'd0, HOLD_LONG},
        '{KIND_PAIR, 3'd1, HOLD_LONG}, '{KIND_PAIR, 3'd0, HOLD_LONG},
        '{KIND_END, 3'd0, 8'd0},
        // blink2
        '{KIND_PAIR, 3'd1, HOLD_SHORT}, '{KIND_PAIR, 3'd0, HOLD_SHORT},
        '{KIND_PAIR, 3'd1, HOLD_SHORT}, '{KIND_PAIR, 3'd0, HOLD_SHORT},
        '{KIND_PAIR, 3'd1, HOLD_SHORT}, '{KIND_PAIR, 3'd0, HOLD_PAUSE},
        '{KIND_AGAIN, 3'd6, 8'd0},
        // blink3
        '{KIND_PAIR, 3'd1, HOLD_SHORT}, '{KIND_PAIR, 3'd0, HOLD_SHORT},
        '{KIND_AGAIN, 3'd2, 8'd0},
        // blink4
        '{KIND_PAIR, 3'd1, HOLD_LONG}, '{KIND_PAIR, 3'd0, HOLD_LONG},
        '{KIND_AGAIN, 3'd2, 8'd0}
    };

    localparam logic [PI_W-1:0] EFFECT_START [KNOWN_EFFECTS] = '{
        5'd0, 5'd2, 5'd4, 5'd9, 5'd16, 5'd19
    };

    // Reads past the end of the table see an end marker.
    function automatic rom_pair_t rom_at(input logic [PI_W:0] idx);
        rom_pair_t r;
        r = END_PAIR;
        if (idx < (PI_W + 1)'(ROM_PAIRS)) begin
            r = PAT_ROM[idx[PI_W-1:0]];
        end
        return r;
    endfunction

endpackage

>>> src/lps_in_reg.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer input register
// Captures one input word and holds it until the processing stage takes it.
// ----------------------------------------------------------------------------
module lps_in_reg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: operation[1:0], channel[2], effect[5:3], clear_first[6]
    input  logic [lps_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            advance,
    output logic                            item_valid,
    output lps_pkg::item_t                  item
);
    import lps_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;
    logic  take;

    assign s_tready   = !valid_reg || advance;
    assign take       = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg.op          <= op_t'(s_tdata[1:0]);
            item_reg.channel     <= s_tdata[2];
            item_reg.effect      <= s_tdata[5:3];
            item_reg.clear_first <= s_tdata[6];
        end
    end

endmodule

>>> src/lps_channel.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer channel
// One channel: effect queue, busy mark and pattern player with hold counter.
// ----------------------------------------------------------------------------
`include "led_pattern_sequencer_top_assert.svh"

module lps_channel (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lps_pkg::chan_ctrl_t  ctrl,
    output lps_pkg::chan_stat_t  stat
);
    import lps_pkg::*;

    logic [EFFECT_W-1:0] store_reg [QUEUE_DEPTH];
    logic [QIDX_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [PI_W-1:0]     pidx_reg, pidx_next;
    logic [HOLD_W-1:0]   hold_reg, hold_next;
    logic                busy_reg, busy_next;

    logic                store_we;
    logic [QIDX_W-1:0]   store_slot;
    logic [QIDX_W-1:0]   eff_head;
    logic [CNT_W-1:0]    eff_count;
    logic [SUM_W-1:0]    slot_sum;
    logic                dropped;
    logic [EFFECT_W-1:0] code;

    logic [HOLD_W-1:0]   hold_dec;
    logic [PI_W:0]       step_idx;
    logic [PI_W:0]       jump_idx;
    rom_pair_t           step_pair;
    rom_pair_t           jump_pair;

    // Tick path: count down, then either stop at an end marker or step on,
    // following a repeat marker back by its distance.
    always_comb begin
        hold_dec  = (hold_reg != '0) ? hold_reg - 1'b1 : '0;
        step_idx  = {1'b0, pidx_reg} + 1'b1;
        step_pair = rom_at(step_idx);
        jump_idx  = step_idx;
        if (step_pair.kind == KIND_AGAIN) begin
            if ({{(PI_W + 1 - ARG_W){1'b0}}, step_pair.arg} <= step_idx) begin
                jump_idx = step_idx - {{(PI_W + 1 - ARG_W){1'b0}}, step_pair.arg};
            end else begin
                jump_idx = '0;
            end
        end
        jump_pair = rom_at(jump_idx);
    end

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        pidx_next  = pidx_reg;
        hold_next  = hold_reg;
        busy_next  = busy_reg;
        store_we   = 1'b0;
        dropped    = 1'b0;
        eff_head   = ctrl.clear_first ? '0 : head_reg;
        eff_count  = ctrl.clear_first ? '0 : count_reg;
        slot_sum   = {{(SUM_W - QIDX_W){1'b0}}, eff_head}
                   + {{(SUM_W - CNT_W){1'b0}}, eff_count};
        if (slot_sum >= SUM_W'(QUEUE_DEPTH)) begin
            store_slot = QIDX_W'(slot_sum - SUM_W'(QUEUE_DEPTH));
        end else begin
            store_slot = QIDX_W'(slot_sum);
        end
        code = store_reg[head_reg];

        if (ctrl.fire) begin
            case (ctrl.op)
                OP_POST: begin
                    if (ctrl.post_hit) begin
                        if (ctrl.clear_first) begin
                            head_next = '0;
                            busy_next = 1'b0;
                        end
                        count_next = eff_count;
                        if (eff_count >= CNT_W'(QUEUE_DEPTH)) begin
                            dropped = 1'b1;
                        end else begin
                            store_we   = 1'b1;
                            count_next = eff_count + 1'b1;
                        end
                    end
                end
                OP_LOAD: begin
                    if (count_reg != '0 && !busy_reg) begin
                        head_next  = (head_reg == QIDX_W'(QUEUE_DEPTH - 1))
                                   ? '0 : head_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                        busy_next  = 1'b1;
                        // Unknown codes mark the channel busy but keep the pattern.
                        if (code < EFFECT_W'(KNOWN_EFFECTS)) begin
                            pidx_next = EFFECT_START[code];
                            hold_next = PAT_ROM[EFFECT_START[code]].hold;
                        end
                    end
                end
                OP_TICK: begin
                    hold_next = hold_dec;
                    if (hold_dec == '0) begin
                        if (step_pair.kind == KIND_END) begin
                            busy_next = 1'b0;
                        end else begin
                            pidx_next = PI_W'(jump_idx);
                            hold_next = jump_pair.hold;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            pidx_reg  <= EFFECT_START[EFF_DARK];
            hold_reg  <= PAT_ROM[EFFECT_START[EFF_DARK]].hold;
            busy_reg  <= 1'b0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            pidx_reg  <= pidx_next;
            hold_reg  <= hold_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[store_slot] <= ctrl.effect;
        end
    end

    // Status reflects the state as it will be after this word is processed.
    assign stat.level   = rom_at({1'b0, pidx_next}).arg[0];
    assign stat.busy    = busy_next;
    assign stat.dropped = dropped;

    `LPS_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(QUEUE_DEPTH))
    `LPS_ASSERT_NEXT(a_load_sets_busy, aclk, aresetn, ctrl.fire && ctrl.op == OP_LOAD && count_reg != '0, busy_reg)
    `LPS_ASSERT_IMPL(a_drop_when_full, aclk, aresetn, dropped, ctrl.post_hit && !ctrl.clear_first && count_reg == CNT_W'(QUEUE_DEPTH))

endmodule

>>> src/led_pattern_sequencer_top.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer top level
// Input register, per-channel sequencers and the result register.
// ----------------------------------------------------------------------------
// A word accepted into the input register moves into the result register when it advances.
// Throughput: one word per cycle; all channels update in parallel from the
// input register into the result register, which stalls only on m_tready.
// Reset (aresetn low, synchronous): queues empty, busy marks clear, every
// channel parked on the dark pattern with its hold count at ten.
`include "led_pattern_sequencer_top_assert.svh"

module led_pattern_sequencer_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: operation[1:0], channel[2], effect[5:3], clear_first[6]
    input  logic [lps_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: levels[1:0], busy_res[3:2], dropped[4]
    output logic [lps_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import lps_pkg::*;

    logic        item_valid;
    item_t       item;
    logic        advance;
    chan_ctrl_t  ctrl [CHANNELS];
    chan_stat_t  stat [CHANNELS];

    logic [CHANNELS-1:0] level_vec;
    logic [CHANNELS-1:0] busy_vec;
    logic [CHANNELS-1:0] drop_vec;
    logic [CHANNELS+LEVEL_W-1:0] level_wide;
    logic [CHANNELS+LEVEL_W-1:0] busy_wide;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [OUT_TDATA_W-1:0] result;

    assign advance = item_valid && (!m_tvalid_reg || m_tready);

    lps_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        assign ctrl[c].fire        = advance;
        assign ctrl[c].op          = item.op;
        assign ctrl[c].post_hit    = ({31'b0, item.channel} == 32'(c));
        assign ctrl[c].clear_first = item.clear_first;
        assign ctrl[c].effect      = item.effect;

        lps_channel u_channel (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl[c]),
            .stat    (stat[c])
        );

        assign level_vec[c] = stat[c].level;
        assign busy_vec[c]  = stat[c].busy;
        assign drop_vec[c]  = stat[c].dropped;
    end

    // Channels beyond the field width are not reported; missing ones read zero.
    assign level_wide = {{LEVEL_W{1'b0}}, level_vec};
    assign busy_wide  = {{LEVEL_W{1'b0}}, busy_vec};
    assign result     = {3'b000, |drop_vec, busy_wide[LEVEL_W-1:0],
                         level_wide[LEVEL_W-1:0]};

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (advance) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `LPS_ASSERT_IMPL(a_drop_only_post, aclk, aresetn, advance && (|drop_vec), item.op == OP_POST)
    `LPS_ASSERT_NEXT(a_result_follows, aclk, aresetn, advance, m_tvalid_reg)
    `LPS_ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !item_valid, s_tready)

endmodule
